// File: rtl/spec_file_tokenizer_assert.svh
// Assertion macros for the spec file tokenizer checker.
// Depends on nothing; included by the checker file.
`ifndef SPEC_FILE_TOKENIZER_ASSERT_SVH
`define SPEC_FILE_TOKENIZER_ASSERT_SVH
// implication checked every clock, off during reset
`define SFT_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
// next-cycle implication
`define SFT_ASSERT_NXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`endif

// File: rtl/sft_pkg.sv
// Shared types, codes and tables of the spec file tokenizer.
// Depends on nothing; used by every module of the block.
package sft_pkg;

	localparam int OFFSET_BITS_DEF = 24;
	localparam int NUMBER_BITS_DEF = 32;
	localparam int KEYWORD_MAX_DEF = 13;

	localparam int OFF_W = 24;
	localparam int NUM_W = 32;

	// character classes
	typedef enum logic [3:0] {
		C_MISC, C_EOF, C_SP, C_LF, C_AHEX, C_ALPHA, C_X, C_DIG, C_ZERO,
		C_DOTSL, C_DQ, C_LB, C_RB, C_RESV, C_HASH
	} cls_t;

	// scan states, one-hot
	typedef enum logic [10:0] {
		S_TOP      = 11'b00000000001,
		S_SECT     = 11'b00000000010,
		S_CMT_TOP  = 11'b00000000100,
		S_CMT_SECT = 11'b00000001000,
		S_KW       = 11'b00000010000,
		S_DIG      = 11'b00000100000,
		S_ZERO     = 11'b00001000000,
		S_HEXLEAD  = 11'b00010000000,
		S_HEX      = 11'b00100000000,
		S_STR      = 11'b01000000000,
		S_PATH     = 11'b10000000000
	} scan_t;

	// transition outcomes
	typedef enum logic [3:0] {
		A_STAY, A_ERR, A_ERRSTR, A_ERRPATH, A_DONE, A_NUM, A_STRING,
		A_PATHTOK, A_KEYWORD, A_BEGIN, A_CLOSE
	} act_t;

	localparam logic [4:0] K_BEGIN = 5'd0;
	localparam logic [4:0] K_CLOSE = 5'd1;
	localparam logic [4:0] K_TRUE  = 5'd21;
	localparam logic [4:0] K_NUM   = 5'd23;
	localparam logic [4:0] K_STR   = 5'd24;
	localparam logic [4:0] K_PATH  = 5'd25;
	localparam logic [4:0] K_DONE  = 5'd26;
	localparam logic [4:0] K_ERR   = 5'd27;

	localparam logic [1:0] E_UNEXP  = 2'd0;
	localparam logic [1:0] E_UNKKW  = 2'd1;
	localparam logic [1:0] E_UNTERM = 2'd2;
	localparam logic [1:0] E_PATH   = 2'd3;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       start_req;
	} in_t;

	typedef struct packed {
		logic [4:0]       token_kind;
		logic [NUM_W-1:0] number_value;
		logic [OFF_W-1:0] text_begin;
		logic [OFF_W-1:0] text_length;
		logic             is_true;
		logic [1:0]       error_code;
		logic [OFF_W-1:0] error_end;
		logic             last;
	} out_t;

	// keyword table, 13 chars max, left aligned, zero padded
	localparam int KW_N = 21;
	localparam int KW_CH = 13;
	typedef logic [8*KW_CH-1:0] kw_word_t;

	function automatic kw_word_t kw_word(input int i);
		case (i)
			0:  kw_word = {"Properties", 24'h0};
			1:  kw_word = {"ARM9", 72'h0};
			2:  kw_word = {"ARM7", 72'h0};
			3:  kw_word = {"Layout", 56'h0};
			4:  kw_word = {"Title", 64'h0};
			5:  kw_word = {"Serial", 56'h0};
			6:  kw_word = {"MakerCode", 32'h0};
			7:  kw_word = {"Revision", 40'h0};
			8:  kw_word = {"ROMType", 48'h0};
			9:  kw_word = {"ROMCapacity", 16'h0};
			10: kw_word = {"PadToEnd", 40'h0};
			11: kw_word = {"CodeBinary", 24'h0};
			12: kw_word = {"Definitions", 16'h0};
			13: kw_word = {"OverlayTable", 8'h0};
			14: kw_word = "SetTargetPath";
			15: kw_word = "SetSourcePath";
			16: kw_word = {"AddFile", 48'h0};
			17: kw_word = {"PROM", 72'h0};
			18: kw_word = {"MROM", 72'h0};
			19: kw_word = {"true", 72'h0};
			20: kw_word = {"false", 64'h0};
			default: kw_word = '0;
		endcase
	endfunction

	function automatic logic [3:0] kw_len(input int i);
		case (i)
			0, 11: kw_len = 4'd10;
			1, 2, 17, 18, 19: kw_len = 4'd4;
			3, 5: kw_len = 4'd6;
			4, 20: kw_len = 4'd5;
			6: kw_len = 4'd9;
			7, 10: kw_len = 4'd8;
			8, 16: kw_len = 4'd7;
			9, 12: kw_len = 4'd11;
			13: kw_len = 4'd12;
			14, 15: kw_len = 4'd13;
			default: kw_len = 4'd0;
		endcase
	endfunction

	function automatic cls_t class_of(input logic [7:0] b);
		if (b[7]) class_of = C_MISC;
		else if (b == 8'h00) class_of = C_EOF;
		else if (b == " " || b == 8'h09 || b == 8'h0d) class_of = C_SP;
		else if (b == 8'h0a) class_of = C_LF;
		else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) class_of = C_AHEX;
		else if (b == "x" || b == "X") class_of = C_X;
		else if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z")) class_of = C_ALPHA;
		else if (b == "0") class_of = C_ZERO;
		else if (b >= "1" && b <= "9") class_of = C_DIG;
		else if (b == "." || b == "/") class_of = C_DOTSL;
		else if (b == 8'h22) class_of = C_DQ;
		else if (b == "{") class_of = C_LB;
		else if (b == "}") class_of = C_RB;
		else if (b == "#") class_of = C_HASH;
		else if (b == "<" || b == ">" || b == 8'h5c || b == "?" || b == "*" ||
			b == ":" || b == "|") class_of = C_RESV;
		else class_of = C_MISC;
	endfunction

	function automatic logic [3:0] hex_value(input logic [7:0] b);
		if (b >= "0" && b <= "9") hex_value = 4'(b - "0");
		else if (b >= "a" && b <= "f") hex_value = 4'(b - "a" + 8'd10);
		else if (b >= "A" && b <= "F") hex_value = 4'(b - "A" + 8'd10);
		else hex_value = 4'd0;
	endfunction

	// transition decision: next scan state when staying, or an outcome
	typedef struct packed {
		act_t  act;
		scan_t nxt;
	} step_t;

endpackage

// File: rtl/spec_file_tokenizer.sv
// Top level of the spec file tokenizer: input register, lexer state, result queue.
// Depends on sft_pkg, sft_next and sft_kwmatch.
//
// Byte-stream lexer for a ROM specification language. One source byte is
// taken per transaction and one byte can be accepted every clock cycle: the
// byte is registered (_s1), then a single table transition computes zero, one
// or two result transactions that go into a four-entry result queue. A byte
// accepted at one edge is written into the queue at the next edge; its first
// result then shows on the output. The only rate limit is the queue: a byte
// is accepted while the queued results plus the results of the byte in the
// input register leave room for two more, so with the output side taking one
// result per cycle the input stalls only around bytes with two results, and a
// stalled output side backs up to the input once three or four results wait.
// A known keyword ended by '{' gives two results: the keyword, then the brace
// (an error in a section). A zero byte at top level or in a comment gives a
// done result; any error gives an error result; both halt the lexer, which
// then drops bytes silently until one carries start_req. Numbers wrap at
// NUMBER_BITS, offsets and lengths saturate at OFFSET_BITS.
module spec_file_tokenizer #(
	parameter int OFFSET_BITS = sft_pkg::OFFSET_BITS_DEF,
	parameter int NUMBER_BITS = sft_pkg::NUMBER_BITS_DEF,
	parameter int KEYWORD_MAX = sft_pkg::KEYWORD_MAX_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  sft_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output sft_pkg::out_t out_data
);
	localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
	localparam int KI_W = $clog2(KEYWORD_MAX);

	// input stage
	logic          v_s1;
	sft_pkg::in_t  d_s1;

	// lexer state
	sft_pkg::scan_t         scan_q;
	logic                   sect_q;
	logic [OFFSET_BITS-1:0] off_q, tstart_q, tcount_q;
	logic [NUMBER_BITS-1:0] acc_q;
	logic [KEYWORD_MAX-1:0][7:0] kw_q;
	logic                   halt_q;

	// result queue, four entries
	sft_pkg::out_t q_q [4];
	logic [2:0]    cnt_q;
	logic [1:0]    rd_q;

	logic in_acc, out_acc;
	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_acc;
		end
	end
	always_ff @(posedge clk) begin
		if (in_acc) d_s1 <= in_data;
	end

	// effective state after an optional restart
	sft_pkg::scan_t         e_scan;
	logic                   e_sect, e_halt;
	logic [OFFSET_BITS-1:0] e_off, e_tstart, e_tcount;
	logic [NUMBER_BITS-1:0] e_acc;
	sft_pkg::cls_t  cls;
	sft_pkg::step_t step;
	logic [4:0]     kw_kind;

	always_comb begin
		if (d_s1.start_req) begin
			e_scan = sft_pkg::S_TOP; e_sect = 1'b0; e_halt = 1'b0;
			e_off = '0; e_tstart = '0; e_tcount = '0; e_acc = '0;
		end else begin
			e_scan = scan_q; e_sect = sect_q; e_halt = halt_q;
			e_off = off_q; e_tstart = tstart_q; e_tcount = tcount_q; e_acc = acc_q;
		end
	end

	assign cls = sft_pkg::class_of(d_s1.text_byte);

	sft_next u_next (.st(e_scan), .c(cls), .step(step));

	sft_kwmatch #(.KEYWORD_MAX(KEYWORD_MAX), .OFFSET_BITS(OFFSET_BITS)) u_kw (
		.chars(kw_q), .count(e_tcount), .kind(kw_kind)
	);

	// token state update when staying in a scan state
	logic                   in_tok_prev, in_tok_nxt;
	logic [OFFSET_BITS-1:0] n_tcount, ebeg;
	logic [NUMBER_BITS-1:0] n_acc;
	sft_pkg::scan_t back;
	assign in_tok_prev = (e_scan == sft_pkg::S_KW) || (e_scan == sft_pkg::S_DIG) ||
		(e_scan == sft_pkg::S_ZERO) || (e_scan == sft_pkg::S_HEXLEAD) ||
		(e_scan == sft_pkg::S_HEX) || (e_scan == sft_pkg::S_STR) ||
		(e_scan == sft_pkg::S_PATH);
	assign in_tok_nxt = (step.nxt == sft_pkg::S_KW) || (step.nxt == sft_pkg::S_DIG) ||
		(step.nxt == sft_pkg::S_ZERO) || (step.nxt == sft_pkg::S_HEXLEAD) ||
		(step.nxt == sft_pkg::S_HEX) || (step.nxt == sft_pkg::S_STR) ||
		(step.nxt == sft_pkg::S_PATH);
	assign ebeg = in_tok_prev ? e_tstart : e_off;
	assign back = e_sect ? sft_pkg::S_SECT : sft_pkg::S_TOP;

	always_comb begin
		n_acc = in_tok_prev ? e_acc : '0;
		n_tcount = !in_tok_prev ? OFFSET_BITS'(1) :
			(e_tcount != OFF_MAX ? e_tcount + 1'b1 : e_tcount);
		if (step.nxt == sft_pkg::S_DIG)
			n_acc = NUMBER_BITS'(n_acc * NUMBER_BITS'(10))
				+ NUMBER_BITS'(d_s1.text_byte[3:0]);
		else if (step.nxt == sft_pkg::S_HEX && e_scan == sft_pkg::S_HEX)
			n_acc = {n_acc[NUMBER_BITS-5:0], 4'b0000}
				| NUMBER_BITS'(sft_pkg::hex_value(d_s1.text_byte));
		else if (step.nxt == sft_pkg::S_HEX)
			n_acc = NUMBER_BITS'(sft_pkg::hex_value(d_s1.text_byte));
	end

	function automatic sft_pkg::out_t mk(input logic [4:0] k, input logic [31:0] nv,
		input logic [OFFSET_BITS-1:0] b, input logic [OFFSET_BITS-1:0] l, input logic t,
		input logic [1:0] ec, input logic [OFFSET_BITS-1:0] ee);
		sft_pkg::out_t o;
		o.token_kind = k; o.number_value = nv;
		o.text_begin = sft_pkg::OFF_W'(b); o.text_length = sft_pkg::OFF_W'(l);
		o.is_true = t; o.error_code = ec; o.error_end = sft_pkg::OFF_W'(ee);
		o.last = 1'b0;
		mk = o;
	endfunction

	// results of this byte
	sft_pkg::out_t r0, r1;
	logic [1:0]    nres;
	sft_pkg::scan_t n_scan;
	logic           n_sect, n_halt;
	logic [31:0]    acc32;
	logic [OFFSET_BITS-1:0] sbeg;
	assign acc32 = 32'(e_acc);
	assign sbeg = (e_tstart != OFF_MAX) ? e_tstart + 1'b1 : OFF_MAX;

	always_comb begin
		r0 = mk(sft_pkg::K_ERR, '0, ebeg, '0, 1'b0, sft_pkg::E_UNEXP, e_off);
		r1 = r0;
		nres = 2'd1;
		n_scan = e_scan; n_sect = e_sect; n_halt = 1'b0;
		case (step.act)
			sft_pkg::A_STAY: begin
				nres = 2'd0; n_scan = step.nxt;
			end
			sft_pkg::A_DONE: begin
				r0 = mk(sft_pkg::K_DONE, '0, e_off, '0, 1'b0, sft_pkg::E_UNEXP, '0);
				n_halt = 1'b1;
			end
			sft_pkg::A_ERRSTR: begin
				r0.error_code = sft_pkg::E_UNTERM; n_halt = 1'b1;
			end
			sft_pkg::A_ERRPATH: begin
				r0.error_code = sft_pkg::E_PATH; n_halt = 1'b1;
			end
			sft_pkg::A_NUM: begin
				r0 = mk(sft_pkg::K_NUM, acc32, e_tstart, '0, 1'b0, sft_pkg::E_UNEXP, '0);
				n_scan = back;
			end
			sft_pkg::A_STRING: begin
				r0 = mk(sft_pkg::K_STR, '0, sbeg, e_tcount - 1'b1, 1'b0,
					sft_pkg::E_UNEXP, '0);
				n_scan = back;
			end
			sft_pkg::A_PATHTOK: begin
				r0 = mk(sft_pkg::K_PATH, '0, e_tstart, e_tcount, 1'b0, sft_pkg::E_UNEXP, '0);
				n_scan = back;
			end
			sft_pkg::A_BEGIN: begin
				r0 = mk(sft_pkg::K_BEGIN, '0, e_off, '0, 1'b0, sft_pkg::E_UNEXP, '0);
				n_sect = 1'b1; n_scan = sft_pkg::S_SECT;
			end
			sft_pkg::A_CLOSE: begin
				r0 = mk(sft_pkg::K_CLOSE, '0, e_off, '0, 1'b0, sft_pkg::E_UNEXP, '0);
				n_sect = 1'b0; n_scan = sft_pkg::S_TOP;
			end
			sft_pkg::A_KEYWORD: begin
				if (kw_kind == '0) begin
					r0.error_code = sft_pkg::E_UNKKW; n_halt = 1'b1;
				end else begin
					r0 = mk(kw_kind, '0, e_tstart, '0, kw_kind == sft_pkg::K_TRUE,
						sft_pkg::E_UNEXP, '0);
					n_scan = back;
					if (cls == sft_pkg::C_LB) begin
						nres = 2'd2;
						if (!e_sect) begin
							r1 = mk(sft_pkg::K_BEGIN, '0, e_off, '0, 1'b0,
								sft_pkg::E_UNEXP, '0);
							n_sect = 1'b1; n_scan = sft_pkg::S_SECT;
						end else begin
							r1 = mk(sft_pkg::K_ERR, '0, e_off, '0, 1'b0,
								sft_pkg::E_UNEXP, e_off);
							n_halt = 1'b1;
						end
					end
				end
			end
			default: n_halt = 1'b1;
		endcase
		if (nres == 2'd1) r0.last = 1'b1;
		if (nres == 2'd2) r1.last = 1'b1;
	end

	logic live;
	assign live = v_s1 && !e_halt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= sft_pkg::S_TOP; sect_q <= 1'b0; halt_q <= 1'b0;
			off_q <= '0; tstart_q <= '0; tcount_q <= '0; acc_q <= '0;
		end else if (v_s1) begin
			scan_q <= e_scan; sect_q <= e_sect; halt_q <= e_halt;
			off_q <= e_off; tstart_q <= e_tstart; tcount_q <= e_tcount; acc_q <= e_acc;
			if (live) begin
				scan_q <= n_scan; sect_q <= n_sect; halt_q <= n_halt;
				off_q <= (e_off != OFF_MAX) ? e_off + 1'b1 : e_off;
				if (step.act == sft_pkg::A_STAY && in_tok_nxt) begin
					tcount_q <= n_tcount; acc_q <= n_acc;
					if (!in_tok_prev) tstart_q <= e_off;
				end
			end
		end
	end

	// keyword characters, written only for the current word
	always_ff @(posedge clk) begin
		if (live && step.act == sft_pkg::A_STAY && step.nxt == sft_pkg::S_KW &&
			(n_tcount - 1'b1) < OFFSET_BITS'(KEYWORD_MAX))
			kw_q[KI_W'(n_tcount - 1'b1)] <= d_s1.text_byte;
	end

	// result queue
	logic [1:0] push;
	assign push = live ? nres : 2'd0;
	// room for the results of the byte in the input register and two more
	assign in_stall = (cnt_q + 3'(push)) > 3'd2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; rd_q <= '0;
		end else begin
			cnt_q <= cnt_q + 3'(push) - 3'(out_acc);
			if (out_acc) rd_q <= rd_q + 2'd1;
		end
	end
	logic [1:0] wp;
	assign wp = rd_q + cnt_q[1:0];
	always_ff @(posedge clk) begin
		if (push != 2'd0) q_q[wp] <= r0;
		if (push == 2'd2) q_q[wp + 2'd1] <= r1;
	end

	assign out_valid = cnt_q != 3'd0;
	assign out_data = q_q[rd_q];
endmodule

// File: rtl/sft_next.sv
// Transition table of the tokenizer: class of byte and scan state to outcome.
// Depends on sft_pkg.
module sft_next (
	input  sft_pkg::scan_t st,
	input  sft_pkg::cls_t  c,
	output sft_pkg::step_t step
);
	logic ws, word, hexd;

	assign ws   = (c == sft_pkg::C_SP) || (c == sft_pkg::C_LF);
	assign word = (c == sft_pkg::C_AHEX) || (c == sft_pkg::C_ALPHA) || (c == sft_pkg::C_X);
	assign hexd = (c == sft_pkg::C_AHEX) || (c == sft_pkg::C_DIG) || (c == sft_pkg::C_ZERO);

	always_comb begin
		step.act = sft_pkg::A_ERR;
		step.nxt = st;
		case (st)
			sft_pkg::S_TOP: begin
				if (c == sft_pkg::C_EOF) step.act = sft_pkg::A_DONE;
				else if (ws) step.act = sft_pkg::A_STAY;
				else if (c == sft_pkg::C_HASH) begin
					step.act = sft_pkg::A_STAY; step.nxt = sft_pkg::S_CMT_TOP;
				end else if (word) begin
					step.act = sft_pkg::A_STAY; step.nxt = sft_pkg::S_KW;
				end else if (c == sft_pkg::C_LB) step.act = sft_pkg::A_BEGIN;
			end
			sft_pkg::S_SECT: begin
				step.act = sft_pkg::A_STAY;
				if (ws) step.nxt = st;
				else if (c == sft_pkg::C_HASH) step.nxt = sft_pkg::S_CMT_SECT;
				else if (word) step.nxt = sft_pkg::S_KW;
				else if (c == sft_pkg::C_DIG) step.nxt = sft_pkg::S_DIG;
				else if (c == sft_pkg::C_ZERO) step.nxt = sft_pkg::S_ZERO;
				else if (c == sft_pkg::C_DQ) step.nxt = sft_pkg::S_STR;
				else if (c == sft_pkg::C_DOTSL) step.nxt = sft_pkg::S_PATH;
				else if (c == sft_pkg::C_RB) step.act = sft_pkg::A_CLOSE;
				else step.act = sft_pkg::A_ERR;
			end
			sft_pkg::S_CMT_TOP: begin
				step.act = (c == sft_pkg::C_EOF) ? sft_pkg::A_DONE : sft_pkg::A_STAY;
				if (c == sft_pkg::C_LF) step.nxt = sft_pkg::S_TOP;
			end
			sft_pkg::S_CMT_SECT: begin
				step.act = (c == sft_pkg::C_EOF) ? sft_pkg::A_DONE : sft_pkg::A_STAY;
				if (c == sft_pkg::C_LF) step.nxt = sft_pkg::S_SECT;
			end
			sft_pkg::S_KW: begin
				if (ws || c == sft_pkg::C_LB) step.act = sft_pkg::A_KEYWORD;
				else if (word || c == sft_pkg::C_DIG || c == sft_pkg::C_ZERO)
					step.act = sft_pkg::A_STAY;
			end
			sft_pkg::S_DIG: begin
				if (ws) step.act = sft_pkg::A_NUM;
				else if (c == sft_pkg::C_DIG) step.act = sft_pkg::A_STAY;
			end
			sft_pkg::S_ZERO: begin
				if (ws) step.act = sft_pkg::A_NUM;
				else if (c == sft_pkg::C_X) begin
					step.act = sft_pkg::A_STAY; step.nxt = sft_pkg::S_HEXLEAD;
				end else if (c == sft_pkg::C_DIG) begin
					step.act = sft_pkg::A_STAY; step.nxt = sft_pkg::S_DIG;
				end
			end
			sft_pkg::S_HEXLEAD: begin
				if (hexd) begin
					step.act = sft_pkg::A_STAY; step.nxt = sft_pkg::S_HEX;
				end
			end
			sft_pkg::S_HEX: begin
				if (ws) step.act = sft_pkg::A_NUM;
				else if (hexd) step.act = sft_pkg::A_STAY;
			end
			sft_pkg::S_STR: begin
				if (c == sft_pkg::C_LF) step.act = sft_pkg::A_ERRSTR;
				else if (c == sft_pkg::C_DQ) step.act = sft_pkg::A_STRING;
				else if (c != sft_pkg::C_EOF) step.act = sft_pkg::A_STAY;
			end
			sft_pkg::S_PATH: begin
				if (ws) step.act = sft_pkg::A_PATHTOK;
				else if (c == sft_pkg::C_DQ || c == sft_pkg::C_LB || c == sft_pkg::C_RB ||
					c == sft_pkg::C_RESV) step.act = sft_pkg::A_ERRPATH;
				else if (c == sft_pkg::C_EOF || c == sft_pkg::C_HASH) step.act = sft_pkg::A_ERR;
				else step.act = sft_pkg::A_STAY;
			end
			default: step.act = sft_pkg::A_ERR;
		endcase
	end
endmodule

// File: rtl/sft_kwmatch.sv
// Keyword matcher: compares the collected word with the fixed keyword table.
// Depends on sft_pkg.
module sft_kwmatch #(
	parameter int KEYWORD_MAX = sft_pkg::KEYWORD_MAX_DEF,
	parameter int OFFSET_BITS = sft_pkg::OFFSET_BITS_DEF
) (
	input  logic [KEYWORD_MAX-1:0][7:0] chars,
	input  logic [OFFSET_BITS-1:0]      count,
	output logic [4:0]                  kind
);
	logic [sft_pkg::KW_CH-1:0][7:0] w;
	sft_pkg::kw_word_t ref_w;
	logic [3:0] len;
	logic hit;

	always_comb begin
		kind = '0;
		for (int i = sft_pkg::KW_N - 1; i >= 0; i--) begin
			ref_w = sft_pkg::kw_word(i);
			len = sft_pkg::kw_len(i);
			hit = (count == OFFSET_BITS'(len));
			for (int j = 0; j < sft_pkg::KW_CH; j++) begin
				w[sft_pkg::KW_CH-1-j] = ref_w[8*(sft_pkg::KW_CH-1-j) +: 8];
				if (j < int'(len) && chars[j] != w[sft_pkg::KW_CH-1-j]) hit = 1'b0;
			end
			if (hit) kind = 5'(i + 2);
		end
	end
endmodule

// File: rtl/sft_checker.sv
// Port-level checker for the spec file tokenizer, bound to the top level.
// Depends on sft_pkg and spec_file_tokenizer_assert.svh.
`include "spec_file_tokenizer_assert.svh"
module sft_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_stall,
	input sft_pkg::in_t  in_data,
	input logic          out_valid,
	input logic          out_stall,
	input sft_pkg::out_t out_data
);
	`SFT_ASSERT_NXT(a_in_hold, clk, arst_n, in_valid && in_stall, in_valid && $stable(in_data))
	`SFT_ASSERT_NXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data))
	`SFT_ASSERT_IMP(a_kind, clk, arst_n, out_valid, out_data.token_kind <= sft_pkg::K_ERR)
	`SFT_ASSERT_IMP(a_code, clk, arst_n, out_valid && out_data.token_kind != sft_pkg::K_ERR, out_data.error_code == sft_pkg::E_UNEXP)
	`SFT_ASSERT_IMP(a_true, clk, arst_n, out_valid && out_data.is_true, out_data.token_kind == sft_pkg::K_TRUE)
endmodule

bind spec_file_tokenizer sft_checker u_sft_checker (.*);
